/* hdl/bez_pkg.sv */
`default_nettype none

package bez_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned FIX_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned T_W        = FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned NUM_PTS    = 4;
  localparam int unsigned NUM_AXES   = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FIX_W-1:0]      fixed_t;
  typedef logic [T_W-1:0]        tval_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam tval_t T_ONE = tval_t'(1) << FRAC_BITS;

  localparam cfg_idx_t REG_P0_X = cfg_idx_t'(0);
  localparam cfg_idx_t REG_P0_Y = cfg_idx_t'(1);
  localparam cfg_idx_t REG_P1_X = cfg_idx_t'(2);
  localparam cfg_idx_t REG_P1_Y = cfg_idx_t'(3);
  localparam cfg_idx_t REG_P2_X = cfg_idx_t'(4);
  localparam cfg_idx_t REG_P2_Y = cfg_idx_t'(5);
  localparam cfg_idx_t REG_P3_X = cfg_idx_t'(6);
  localparam cfg_idx_t REG_P3_Y = cfg_idx_t'(7);

  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;

  // First level: integer endpoints, result exact in Q.FRAC
  function automatic fixed_t lerp_coord(coord_t a, coord_t b, tval_t t, tval_t omt);
    logic [COORD_BITS+T_W-1:0] pa;
    logic [COORD_BITS+T_W-1:0] pb;
    logic [COORD_BITS+T_W:0]   s;
    pa = (COORD_BITS+T_W)'(a) * (COORD_BITS+T_W)'(omt);
    pb = (COORD_BITS+T_W)'(b) * (COORD_BITS+T_W)'(t);
    s  = {1'b0, pa} + {1'b0, pb};
    return s[FIX_W-1:0];
  endfunction

  // Later levels: fixed-point endpoints, truncate the fraction
  function automatic fixed_t lerp_fixed(fixed_t a, fixed_t b, tval_t t, tval_t omt);
    logic [FIX_W+T_W-1:0] pa;
    logic [FIX_W+T_W-1:0] pb;
    logic [FIX_W+T_W:0]   s;
    pa = (FIX_W+T_W)'(a) * (FIX_W+T_W)'(omt);
    pb = (FIX_W+T_W)'(b) * (FIX_W+T_W)'(t);
    s  = {1'b0, pa} + {1'b0, pb};
    return s[FIX_W+FRAC_BITS-1:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

/* hdl/cubic_bezier_de_casteljau_top.sv */
// Cubic Bezier point evaluator (de Casteljau, fixed point).
//
// Configuration: write control point coordinates through cfg_valid_i /
// cfg_ready_o with cfg_index_i (0..7: p0_x, p0_y, ... p3_y) and cfg_data_i.
// cfg_ready_o is always high; indexes above 7 are dropped. Write only while
// no beat is in flight.
//
// Input: a beat is taken when start_i is high and busy_o is low. busy_o is
// always low, so a new t_value_i may be issued every cycle. t above one
// saturates to one.
//
// Output: result_valid_o strobes for one cycle with x/y in Q10.16 and the
// floor pixel coordinates. The pipeline has four register stages (t
// saturate, then one interpolation level each); throughput is one beat per
// cycle. The receiver cannot stall, so results are never held.
//
// Reset: control points clear to zero and the pipeline empties.
`default_nettype none

module cubic_bezier_de_casteljau_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [bez_pkg::T_W-1:0]      t_value_i,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [bez_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [bez_pkg::COORD_BITS-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output logic [bez_pkg::FIX_W-1:0]    x_fixed_o,
  output logic [bez_pkg::FIX_W-1:0]    y_fixed_o,
  output logic [bez_pkg::COORD_BITS-1:0] x_pixel_o,
  output logic [bez_pkg::COORD_BITS-1:0] y_pixel_o
);
  import bez_pkg::*;

  coord_t pt_q [NUM_PTS][NUM_AXES];
  coord_t pt_d [NUM_PTS][NUM_AXES];

  logic   v0_q, v1_q, v2_q, v3_q;
  tval_t  t0_q, omt0_q, t1_q, omt1_q, t2_q, omt2_q;
  fixed_t b_q [3][NUM_AXES];
  fixed_t b_d [3][NUM_AXES];
  fixed_t d_q [2][NUM_AXES];
  fixed_t d_d [2][NUM_AXES];
  fixed_t r_q [NUM_AXES];
  fixed_t r_d [NUM_AXES];
  tval_t  t_sat;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    pt_d = pt_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_P0_X: pt_d[0][AX_X] = cfg_data_i;
        REG_P0_Y: pt_d[0][AX_Y] = cfg_data_i;
        REG_P1_X: pt_d[1][AX_X] = cfg_data_i;
        REG_P1_Y: pt_d[1][AX_Y] = cfg_data_i;
        REG_P2_X: pt_d[2][AX_X] = cfg_data_i;
        REG_P2_Y: pt_d[2][AX_Y] = cfg_data_i;
        REG_P3_X: pt_d[3][AX_X] = cfg_data_i;
        REG_P3_Y: pt_d[3][AX_Y] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PTS; p++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          pt_q[p][a] <= '0;
        end
      end
    end else begin
      pt_q <= pt_d;
    end
  end

  assign t_sat = (t_value_i > T_ONE) ? T_ONE : t_value_i;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < 3; k++) begin
        b_d[k][a] = lerp_coord(pt_q[k][a], pt_q[k+1][a], t0_q, omt0_q);
      end
      for (int k = 0; k < 2; k++) begin
        d_d[k][a] = lerp_fixed(b_q[k][a], b_q[k+1][a], t1_q, omt1_q);
      end
      r_d[a] = lerp_fixed(d_q[0][a], d_q[1][a], t2_q, omt2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q   <= t_sat;
    omt0_q <= T_ONE - t_sat;
    t1_q   <= t0_q;
    omt1_q <= omt0_q;
    t2_q   <= t1_q;
    omt2_q <= omt1_q;
    b_q    <= b_d;
    d_q    <= d_d;
    r_q    <= r_d;
  end

  assign result_valid_o = v3_q;
  assign x_fixed_o      = r_q[AX_X];
  assign y_fixed_o      = r_q[AX_Y];
  assign x_pixel_o      = r_q[AX_X][FIX_W-1:FRAC_BITS];
  assign y_pixel_o      = r_q[AX_Y][FIX_W-1:FRAC_BITS];

endmodule

`default_nettype wire

/* tb/tb_cubic_bezier_de_casteljau_top.sv */
`default_nettype none

module tb_cubic_bezier_de_casteljau_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bez_pkg::*;

  localparam int PIPE_LAT    = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int SWEEPS      = 13;
  localparam int SWEEP_ITEMS = 102;
  localparam int FIRST_STRAY = int'(REG_P3_Y) + 1;
  localparam int LAST_STRAY  = (1 << CFG_IDX_W) - 1;

  typedef longint unsigned u64_t;

  typedef struct {
    fixed_t x_fix;
    fixed_t y_fix;
    coord_t x_pix;
    coord_t y_pix;
  } curve_point_t;

  class bezier_point_board;
    coord_t       ctrl_x[NUM_PTS];
    coord_t       ctrl_y[NUM_PTS];
    curve_point_t pending_points[$];
    int           mismatches;

    function new();
      foreach (ctrl_x[i]) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, coord_t v);
      case (idx)
        REG_P0_X: ctrl_x[0] = v;
        REG_P0_Y: ctrl_y[0] = v;
        REG_P1_X: ctrl_x[1] = v;
        REG_P1_Y: ctrl_y[1] = v;
        REG_P2_X: ctrl_x[2] = v;
        REG_P2_Y: ctrl_y[2] = v;
        REG_P3_X: ctrl_x[3] = v;
        REG_P3_Y: ctrl_y[3] = v;
        default: ;
      endcase
    endfunction

    function u64_t blend(u64_t a, u64_t b, u64_t t);
      return (a * ((u64_t'(1) << FRAC_BITS) - t) + b * t) >> FRAC_BITS;
    endfunction

    function fixed_t casteljau_axis(coord_t c[NUM_PTS], tval_t t_in);
      u64_t t;
      u64_t pts[NUM_PTS];
      t = (t_in > T_ONE) ? u64_t'(T_ONE) : u64_t'(t_in);
      foreach (pts[i]) pts[i] = u64_t'(c[i]) << FRAC_BITS;
      for (int lvl = NUM_PTS - 1; lvl > 0; lvl--) begin
        for (int i = 0; i < lvl; i++) pts[i] = blend(pts[i], pts[i+1], t);
      end
      return fixed_t'(pts[0]);
    endfunction

    function void note_t(tval_t t_in);
      curve_point_t p;
      p.x_fix = casteljau_axis(ctrl_x, t_in);
      p.y_fix = casteljau_axis(ctrl_y, t_in);
      p.x_pix = coord_t'(p.x_fix >> FRAC_BITS);
      p.y_pix = coord_t'(p.y_fix >> FRAC_BITS);
      pending_points = {pending_points, p};
    endfunction

    function void check_field(string name, u64_t exp_v, u64_t act_v);
      if (exp_v != act_v) begin
        $error("%s expected %0d actual %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_point(fixed_t xf, fixed_t yf, coord_t xp, coord_t yp);
      curve_point_t p;
      if (pending_points.size() == 0) begin
        $error("result beat with no point pending");
        mismatches++;
        return;
      end
      p = pending_points.pop_front();
      check_field("x_fixed", p.x_fix, xf);
      check_field("y_fixed", p.y_fix, yf);
      check_field("x_pixel", p.x_pix, xp);
      check_field("y_pixel", p.y_pix, yp);
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     start_i     = 1'b0;
  tval_t    t_value_i   = '0;
  logic     cfg_valid_i = 1'b0;
  cfg_idx_t cfg_index_i = '0;
  coord_t   cfg_data_i  = '0;
  logic     busy_o;
  logic     cfg_ready_o;
  logic     result_valid_o;
  fixed_t   x_fixed_o;
  fixed_t   y_fixed_o;
  coord_t   x_pixel_o;
  coord_t   y_pixel_o;

  bezier_point_board board = new();

  tval_t corner_ts[7] = '{tval_t'(0), tval_t'(1), T_ONE >> 1, T_ONE - 1, T_ONE,
                          T_ONE + 1, '1};

  cubic_bezier_de_casteljau_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .t_value_i      (t_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .x_fixed_o      (x_fixed_o),
    .y_fixed_o      (y_fixed_o),
    .x_pixel_o      (x_pixel_o),
    .y_pixel_o      (y_pixel_o)
  );

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (result_valid_o) board.check_point(x_fixed_o, y_fixed_o, x_pixel_o, y_pixel_o);
      if (start_i && !busy_o) board.note_t(t_value_i);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL cubic_bezier_de_casteljau_top");
    $finish;
  end

  task automatic write_reg_beat(cfg_idx_t idx, coord_t v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_points(coord_t xs[NUM_PTS], coord_t ys[NUM_PTS]);
    cfg_idx_t x_regs[NUM_PTS];
    cfg_idx_t y_regs[NUM_PTS];
    x_regs = '{REG_P0_X, REG_P1_X, REG_P2_X, REG_P3_X};
    y_regs = '{REG_P0_Y, REG_P1_Y, REG_P2_Y, REG_P3_Y};
    for (int i = 0; i < NUM_PTS; i++) begin
      write_reg_beat(x_regs[i], xs[i]);
      write_reg_beat(y_regs[i], ys[i]);
    end
    // stray indexes must leave the points untouched
    repeat ($urandom_range(1, 3)) begin
      write_reg_beat(cfg_idx_t'($urandom_range(FIRST_STRAY, LAST_STRAY)), coord_t'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_t(tval_t t);
    start_i   <= 1'b1;
    t_value_i <= t;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_burst();
    start_i   <= 1'b0;
    t_value_i <= tval_t'($urandom);
    repeat ($urandom_range(1, 15)) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  function automatic tval_t random_t();
    case ($urandom_range(0, 9))
      0: return corner_ts[$urandom_range(0, 6)];
      1: return tval_t'($urandom_range(int'(T_ONE) + 1, (1 << T_W) - 1));
      default: return tval_t'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic sweep(int count, bit with_gaps);
    int gap_odds;
    gap_odds = $urandom_range(2, 12);
    for (int i = 0; i < count; i++) begin
      if (with_gaps && $urandom_range(1, gap_odds) == 1) idle_burst();
      send_t(random_t());
    end
  endtask

  initial begin
    coord_t xs[NUM_PTS];
    coord_t ys[NUM_PTS];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_ts[i]) send_t(corner_ts[i]);
    drain();

    xs = '{default: '1};
    ys = '{default: '1};
    load_points(xs, ys);
    foreach (corner_ts[i]) send_t(corner_ts[i]);
    drain();

    xs = '{'0, '1, '0, '1};
    ys = '{'1, '0, '1, '0};
    load_points(xs, ys);
    foreach (corner_ts[i]) send_t(corner_ts[i]);
    drain();

    for (int s = 0; s < SWEEPS; s++) begin
      foreach (xs[i]) begin
        xs[i] = random_coord();
        ys[i] = random_coord();
      end
      load_points(xs, ys);
      sweep(SWEEP_ITEMS, s < SWEEPS - 1);
      drain();
    end

    if (board.mismatches == 0 && board.pending_points.size() == 0) begin
      $display("PASS cubic_bezier_de_casteljau_top");
    end else begin
      $display("FAIL cubic_bezier_de_casteljau_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
